@@ hdl/cbc_pkg.sv @@
package cbc_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam int CHAR_LOW    = 32;
    localparam int CHAR_HIGH   = 126;
    localparam int ROWS        = 126 - 32 + 1;
    localparam int COLS        = ROWS + 1;
    localparam int END_COL     = COLS - 1;
    localparam int TABLE_DEPTH = ROWS * COLS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CHAR_W      = 7;

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [6:0] row_index;
        logic [6:0] col_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] count;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_UPDATE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } req_t;

    // row * 96 + col as shifts
    function automatic logic [ADDR_W-1:0] table_addr(input logic [6:0] row,
                                                     input logic [6:0] col);
        logic [ADDR_W-1:0] r;
        r = ADDR_W'(row);
        return (r << 6) + (r << 5) + ADDR_W'(col);
    endfunction

endpackage

@@ hdl/cbc_count_ram.sv @@
module cbc_count_ram #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [cbc_pkg::ADDR_W-1:0]     rd_addr,
    output logic [COUNT_BITS-1:0]          rd_data,
    input  logic                           wr_en,
    input  logic [cbc_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [COUNT_BITS-1:0]          wr_data,
    output logic                           init_done
);

    localparam logic [cbc_pkg::ADDR_W-1:0] LAST_ADDR =
        cbc_pkg::ADDR_W'(cbc_pkg::TABLE_DEPTH - 1);

    logic [COUNT_BITS-1:0]       mem [cbc_pkg::TABLE_DEPTH];
    logic [COUNT_BITS-1:0]       rd_data_reg;
    logic [cbc_pkg::ADDR_W-1:0]  init_addr_reg;
    logic [cbc_pkg::ADDR_W-1:0]  init_addr_next;
    logic                        init_busy_reg;
    logic                        init_busy_next;
    logic                        mem_we;
    logic [cbc_pkg::ADDR_W-1:0]  mem_waddr;
    logic [COUNT_BITS-1:0]       mem_wdata;

    // clearing sweep writes one to every entry after reset
    always_comb begin
        init_addr_next = init_addr_reg;
        init_busy_next = init_busy_reg;
        if (init_busy_reg) begin
            init_addr_next = init_addr_reg + 1'b1;
            if (init_addr_reg == LAST_ADDR) begin
                init_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_addr_reg <= '0;
            init_busy_reg <= 1'b1;
        end else begin
            init_addr_reg <= init_addr_next;
            init_busy_reg <= init_busy_next;
        end
    end

    assign mem_we    = init_busy_reg || wr_en;
    assign mem_waddr = init_busy_reg ? init_addr_reg : wr_addr;
    assign mem_wdata = init_busy_reg ? COUNT_BITS'(1) : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = !init_busy_reg;

endmodule

@@ hdl/cbc_front.sv @@
module cbc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  cbc_pkg::in_item_t  item,
    output cbc_pkg::req_t      req
);

    logic [cbc_pkg::CHAR_W-1:0] prev_char_reg;
    logic [cbc_pkg::CHAR_W-1:0] prev_char_next;
    logic                       have_prev_reg;
    logic                       have_prev_next;
    logic                       pair_seen_reg;
    logic                       pair_seen_next;
    logic                       char_ok;
    logic [cbc_pkg::CHAR_W-1:0] char_idx;

    assign char_ok  = (item.char_code >= 8'(cbc_pkg::CHAR_LOW))
                   && (item.char_code <= 8'(cbc_pkg::CHAR_HIGH));
    assign char_idx = cbc_pkg::CHAR_W'(item.char_code - 8'(cbc_pkg::CHAR_LOW));

    always_comb begin
        req.kind       = cbc_pkg::KIND_NONE;
        req.status     = cbc_pkg::STATUS_OK;
        req.addr       = cbc_pkg::table_addr(prev_char_reg, char_idx);
        prev_char_next = prev_char_reg;
        have_prev_next = have_prev_reg;
        pair_seen_next = pair_seen_reg;
        case (item.op)
            cbc_pkg::OP_CHAR: begin
                if (!char_ok) begin
                    req.status = cbc_pkg::STATUS_BAD_CHAR;
                end else begin
                    if (have_prev_reg) begin
                        req.kind       = cbc_pkg::KIND_UPDATE;
                        pair_seen_next = 1'b1;
                    end
                    prev_char_next = char_idx;
                    have_prev_next = 1'b1;
                end
            end
            cbc_pkg::OP_END: begin
                req.addr = cbc_pkg::table_addr(prev_char_reg, 7'(cbc_pkg::END_COL));
                if (pair_seen_reg) begin
                    req.kind = cbc_pkg::KIND_UPDATE;
                end
                have_prev_next = 1'b0;
                pair_seen_next = 1'b0;
            end
            cbc_pkg::OP_READ: begin
                req.addr = cbc_pkg::table_addr(item.row_index, item.col_index);
                if ((item.row_index >= 7'(cbc_pkg::ROWS))
                        || (item.col_index >= 7'(cbc_pkg::COLS))) begin
                    req.status = cbc_pkg::STATUS_BAD_INDEX;
                end else begin
                    req.kind = cbc_pkg::KIND_READ;
                end
            end
            default: begin
                req.kind = cbc_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_char_reg <= '0;
            have_prev_reg <= 1'b0;
            pair_seen_reg <= 1'b0;
        end else if (accept) begin
            prev_char_reg <= prev_char_next;
            have_prev_reg <= have_prev_next;
            pair_seen_reg <= pair_seen_next;
        end
    end

endmodule

@@ hdl/cbc_update.sv @@
module cbc_update #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  cbc_pkg::req_t               req,
    input  logic [COUNT_BITS-1:0]       rd_data,
    output logic                        stage_free,
    output logic                        wr_en,
    output logic [cbc_pkg::ADDR_W-1:0]  wr_addr,
    output logic [COUNT_BITS-1:0]       wr_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cbc_pkg::out_item_t          m_item
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    cbc_pkg::req_t              s1_req_reg;
    logic                       fwd_hit_reg;
    logic [COUNT_BITS-1:0]      fwd_data_reg;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    cbc_pkg::out_item_t         m_item_reg;
    cbc_pkg::out_item_t         m_item_next;
    logic                       advance;
    logic [COUNT_BITS-1:0]      cur_count;
    logic [COUNT_BITS-1:0]      new_count;
    logic [COUNT_BITS+31:0]     show_ext;

    assign advance    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign stage_free = !s1_valid_reg || advance;

    // write lands at the same edge as the next read of that entry
    assign cur_count = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign new_count = (cur_count == COUNT_MAX) ? cur_count
                                                : cur_count + COUNT_BITS'(1);

    assign wr_en   = advance && (s1_req_reg.kind == cbc_pkg::KIND_UPDATE);
    assign wr_addr = s1_req_reg.addr;
    assign wr_data = new_count;

    always_comb begin
        show_ext = '0;
        case (s1_req_reg.kind)
            cbc_pkg::KIND_UPDATE: show_ext = {32'b0, new_count};
            cbc_pkg::KIND_READ:   show_ext = {32'b0, cur_count};
            default:              show_ext = '0;
        endcase
        m_item_next.status = s1_req_reg.status;
        m_item_next.count  = show_ext[31:0];
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg   <= req;
            fwd_hit_reg  <= wr_en && (wr_addr == req.addr);
            fwd_data_reg <= new_count;
        end
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ hdl/char_bigram_counter.sv @@
// channel   ports                      contents
// input     s_valid s_ready s_item     op, char_code, row_index, col_index
// result    m_valid m_ready m_item     status, count
//
// one item per cycle unless the result stalls; m_valid rises as the item leaves the update stage
// one table read per item, a write per counted pair or word end, same-entry overlap forwarded
// after reset the table sweep sets every entry to one, s_ready low meanwhile
// a stalled result holds one item in the update stage, then s_ready drops
module char_bigram_counter #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbc_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cbc_pkg::out_item_t  m_item
);

    logic                        accept;
    logic                        init_done;
    logic                        stage_free;
    cbc_pkg::req_t               req;
    logic [COUNT_BITS-1:0]       rd_data;
    logic                        wr_en;
    logic [cbc_pkg::ADDR_W-1:0]  wr_addr;
    logic [COUNT_BITS-1:0]       wr_data;

    assign s_ready = init_done && stage_free;
    assign accept  = s_valid && s_ready;

    cbc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .req     (req)
    );

    cbc_count_ram #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ram (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (req.addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .init_done (init_done)
    );

    cbc_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req        (req),
        .rd_data    (rd_data),
        .stage_free (stage_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

@@ tb/char_bigram_counter_tb.sv @@
`timescale 1ns / 1ps

module char_bigram_counter_tb;

    import cbc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        in_item_t  item;
        logic      pinned;
        out_item_t want;
    } probe_t;

    localparam int N_DIRECTED = 25;

    // pinned rows carry a result readable at a glance, the rest go through the predictor
    localparam probe_t DIRECTED [N_DIRECTED] = '{
        '{'{OP_READ,   8'd0,   7'd0,   7'd0},   1'b1, '{STATUS_OK,        32'd1}},
        '{'{OP_READ,   8'd0,   7'd94,  7'd95},  1'b1, '{STATUS_OK,        32'd1}},
        '{'{OP_READ,   8'd0,   7'd95,  7'd0},   1'b1, '{STATUS_BAD_INDEX, 32'd0}},
        '{'{OP_READ,   8'd0,   7'd0,   7'd96},  1'b1, '{STATUS_BAD_INDEX, 32'd0}},
        '{'{OP_READ,   8'd0,   7'd127, 7'd127}, 1'b1, '{STATUS_BAD_INDEX, 32'd0}},
        '{'{OP_READ,   8'd255, 7'd94,  7'd0},   1'b1, '{STATUS_OK,        32'd1}},
        '{'{OP_CHAR,   8'd0,   7'd127, 7'd127}, 1'b1, '{STATUS_BAD_CHAR,  32'd0}},
        '{'{OP_CHAR,   8'd31,  7'd0,   7'd0},   1'b1, '{STATUS_BAD_CHAR,  32'd0}},
        '{'{OP_CHAR,   8'd127, 7'd0,   7'd0},   1'b1, '{STATUS_BAD_CHAR,  32'd0}},
        '{'{OP_CHAR,   8'd255, 7'd0,   7'd0},   1'b1, '{STATUS_BAD_CHAR,  32'd0}},
        '{'{OP_END,    8'd0,   7'd0,   7'd0},   1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd32,  7'd0,   7'd0},   1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_END,    8'd255, 7'd127, 7'd127}, 1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd126, 7'd0,   7'd0},   1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd126, 7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd128, 7'd0,   7'd0},   1'b1, '{STATUS_BAD_CHAR,  32'd0}},
        '{'{OP_CHAR,   8'd32,  7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_END,    8'd0,   7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_READ,   8'd0,   7'd94,  7'd94},  1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_UNUSED, 8'd255, 7'd127, 7'd127}, 1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd97,  7'd0,   7'd0},   1'b1, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd98,  7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_CHAR,   8'd97,  7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_END,    8'd0,   7'd0,   7'd0},   1'b0, '{STATUS_OK,        32'd0}},
        '{'{OP_READ,   8'd0,   7'd65,  7'd66},  1'b0, '{STATUS_OK,        32'd0}}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic [COUNT_BITS_DEF-1:0] count_table [TABLE_DEPTH];
    logic [6:0] last_char;
    logic       word_open;
    logic       word_has_pair;

    probe_t    feed_q  [$];
    out_item_t tally_q [$];

    int fault_n    = 0;
    int results_n  = 0;
    int sent_n     = 0;
    int pairs_n    = 0;
    int ends_n     = 0;
    int reads_n    = 0;
    int rejected_n = 0;
    int bad_idx_n  = 0;

    char_bigram_counter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] bump_pair(int row, int col);
        int slot;
        slot = row * COLS + col;
        if (count_table[slot] != '1) begin
            count_table[slot] = count_table[slot] + 1'b1;
        end
        return count_table[slot][31:0];
    endfunction

    function automatic out_item_t tally_step(in_item_t it);
        out_item_t res;
        res.status = STATUS_OK;
        res.count  = '0;
        case (it.op)
            OP_CHAR: begin
                if (it.char_code < CHAR_LOW || it.char_code > CHAR_HIGH) begin
                    res.status = STATUS_BAD_CHAR;
                    rejected_n++;
                end else begin
                    if (word_open) begin
                        res.count     = bump_pair(int'(last_char),
                                                  int'(it.char_code) - CHAR_LOW);
                        word_has_pair = 1'b1;
                        pairs_n++;
                    end
                    last_char = 7'(it.char_code - CHAR_LOW);
                    word_open = 1'b1;
                end
            end
            OP_END: begin
                if (word_has_pair) begin
                    res.count = bump_pair(int'(last_char), END_COL);
                    ends_n++;
                end
                word_open     = 1'b0;
                word_has_pair = 1'b0;
            end
            OP_READ: begin
                if (it.row_index >= ROWS || it.col_index >= COLS) begin
                    res.status = STATUS_BAD_INDEX;
                    bad_idx_n++;
                end else begin
                    res.count = count_table[it.row_index * COLS + it.col_index][31:0];
                    reads_n++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic probe_t loose(in_item_t it);
        probe_t p;
        p.item   = it;
        p.pinned = 1'b0;
        p.want   = '0;
        return p;
    endfunction

    function automatic in_item_t noise_item(logic [1:0] op);
        in_item_t it;
        it.op        = op;
        it.char_code = 8'($urandom);
        it.row_index = 7'($urandom);
        it.col_index = 7'($urandom);
        return it;
    endfunction

    // mostly whole words over a narrow or wide alphabet, with reads and noise mixed in
    task automatic queue_random(int n_items);
        in_item_t it;
        int       roll;
        int       len;
        int       narrow;
        int       queued;
        queued = 0;
        while (queued < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                len    = $urandom_range(1, 8);
                narrow = $urandom_range(0, 1);
                for (int k = 0; k < len; k++) begin
                    it = noise_item(OP_CHAR);
                    if ($urandom_range(0, 19) == 0) begin
                        it.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                            : 8'($urandom_range(127, 255));
                    end else if (narrow != 0) begin
                        it.char_code = 8'($urandom_range(97, 100));
                    end else begin
                        it.char_code = 8'($urandom_range(32, 126));
                    end
                    feed_q.push_back(loose(it));
                    queued++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    feed_q.push_back(loose(noise_item(OP_END)));
                    queued++;
                end
            end else if (roll < 82) begin
                it = noise_item(OP_READ);
                if ($urandom_range(0, 1) != 0) begin
                    it.row_index = 7'($urandom_range(65, 68));
                    it.col_index = ($urandom_range(0, 4) == 0) ? 7'(END_COL)
                                                               : 7'($urandom_range(65, 68));
                end else begin
                    it.row_index = 7'($urandom_range(0, ROWS - 1));
                    it.col_index = 7'($urandom_range(0, COLS - 1));
                end
                feed_q.push_back(loose(it));
                queued++;
            end else if (roll < 90) begin
                feed_q.push_back(loose(noise_item(OP_READ)));
                queued++;
            end else if (roll < 95) begin
                feed_q.push_back(loose(noise_item(OP_CHAR)));
                queued++;
            end else if (roll < 98) begin
                feed_q.push_back(loose(noise_item(OP_END)));
                queued++;
            end else begin
                feed_q.push_back(loose(noise_item(OP_UNUSED)));
                queued++;
            end
        end
    endtask

    task automatic flag_fault(string msg);
        if (fault_n < 10) begin
            $display("%0t: %s", $time, msg);
        end
        fault_n++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        results_n++;
        if (tally_q.size() == 0) begin
            flag_fault($sformatf("unexpected result transfer: status %0d count %0d",
                                 got.status, got.count));
            return;
        end
        want = tally_q.pop_front();
        if (got.status !== want.status) begin
            flag_fault($sformatf("result %0d status: expected %0d, got %0d",
                                 results_n, want.status, got.status));
        end
        if (got.count !== want.count) begin
            flag_fault($sformatf("result %0d count: expected %0d, got %0d",
                                 results_n, want.count, got.count));
        end
    endtask

    initial begin : result_sink
        int  gap;
        bit  held;
        held = 1'b0;
        forever begin
            gap = (results_n % 128 < 32) ? 0 : $urandom_range(0, 4);
            if (!held && results_n >= HOLD_AT) begin
                // long stall so the block backs up into its input
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_result(m_item);
        end
    end

    initial begin : stimulus
        probe_t    p;
        out_item_t predicted;
        int        gap;
        int        idx;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            count_table[i] = 1;
        end
        last_char     = '0;
        word_open     = 1'b0;
        word_has_pair = 1'b0;
        foreach (DIRECTED[i]) begin
            feed_q.push_back(DIRECTED[i]);
        end
        queue_random(RANDOM_ITEMS);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        idx = 0;
        while (feed_q.size() != 0) begin
            p   = feed_q.pop_front();
            gap = (idx % 160 < 40) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_item  <= p.item;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            predicted = tally_step(p.item);
            tally_q.push_back(p.pinned ? p.want : predicted);
            sent_n++;
            idx++;
        end
        s_valid <= 1'b0;

        while (tally_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("ran %0d transfers (%0d directed), checked %0d results, %0d faults",
                 sent_n, N_DIRECTED, results_n, fault_n);
        $display("pairs %0d, word ends %0d, reads %0d, bad chars %0d, bad index reads %0d",
                 pairs_n, ends_n, reads_n, rejected_n, bad_idx_n);
        if (fault_n == 0 && tally_q.size() == 0) begin
            $display("char_bigram_counter_tb: PASS");
        end else begin
            $display("char_bigram_counter_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results pending", tally_q.size());
        $display("char_bigram_counter_tb: FAIL");
        $finish;
    end

endmodule
